### hw/rtl/arpc_pkg.sv
package arpc_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} arpc_state_t;

	// Search beat handed from one cache cell to the next.
	typedef struct packed {
		logic        vld;
		logic [31:0] ip;
		logic        hit;
		logic [47:0] mac;
	} arpc_tok_t;

	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_ADD    = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_MISS     = 2'd1;
	localparam logic [1:0] STAT_NOT_OURS = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

endpackage

### hw/rtl/arpc_cell.sv
module arpc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [31:0]       wr_ip,
	input  logic [47:0]       wr_mac,
	input  arpc_pkg::arpc_tok_t tok_in,
	output arpc_pkg::arpc_tok_t tok_out
);
	import arpc_pkg::*;

	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	arpc_tok_t   tok_q;
	arpc_tok_t   tok_d;

	// An earlier cell's hit is kept, so the earliest match wins.
	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && valid_q && (ip_q == tok_in.ip)) begin
			tok_d.hit = 1'b1;
			tok_d.mac = mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_q  <= wr_ip;
			mac_q <= wr_mac;
		end
	end

	assign tok_out = tok_q;

endmodule

### hw/rtl/arp_cache_and_responder_top.sv
// Channel   Handshake                  Payload
// in        in_valid / in_stall        command, arp_operation, sender_ip, sender_mac,
//                                      target_ip, query_ip
// out       out_valid / out_stall      status, reply_needed, request_needed, dest_mac,
//                                      dest_ip, found_mac
// config    APB (psel, penable, ...)   own_ip at 0x0, own_mac at 0x8, 64-bit data
//
// A command that touches the cache is accepted, its search beat then walks the chain
// through one register per cell, and its result is then written to the output register.
// Other commands skip the search. One item is in flight at a time; in_stall is high
// from acceptance until the result has been loaded into the output register.
// Reset clears the configuration registers, the state, the output valid bit, the cell valid bits and the fill count.
// A stalled result holds the block in its final cycle until the output register frees.
module arp_cache_and_responder_top #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] arp_operation,
	input  logic [31:0] sender_ip,
	input  logic [47:0] sender_mac,
	input  logic [31:0] target_ip,
	input  logic [31:0] query_ip,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        reply_needed,
	output logic        request_needed,
	output logic [47:0] dest_mac,
	output logic [31:0] dest_ip,
	output logic [47:0] found_mac
);
	import arpc_pkg::*;

	localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	arpc_state_t state_q, state_d;

	logic [1:0]  cmd_q;
	logic [15:0] op_q;
	logic [31:0] sip_q;
	logic [47:0] smac_q;
	logic [31:0] qip_q;
	logic        not_ours_q;
	logic        hit_q;
	logic [47:0] fmac_q;
	logic [CNTW-1:0] count_q;

	logic        accept;
	logic        not_ours;
	logic        needs_search;
	logic        launch;
	logic        commit;
	logic        do_insert;
	logic        write_entry;
	logic        full;

	logic [1:0]  res_status;
	logic        res_reply;
	logic        res_request;
	logic [47:0] res_dmac;
	logic [31:0] res_dip;
	logic [47:0] res_fmac;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        reply_q;
	logic        request_q;
	logic [47:0] dmac_q;
	logic [31:0] dip_q;
	logic [47:0] found_q;

	arpc_tok_t chain [0:TABLE_ENTRIES];

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_OWN_MAC) ? {16'd0, own_mac_q} : {32'd0, own_ip_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == REG_OWN_MAC) begin
				own_mac_q <= pwdata[47:0];
			end else begin
				own_ip_q <= pwdata[31:0];
			end
		end
	end

	assign accept   = in_valid && !in_stall;
	assign not_ours = (target_ip != own_ip_q);
	assign needs_search = (command == CMD_LOOKUP) || (command == CMD_ADD) ||
		((command == CMD_PACKET) && !not_ours && (arp_operation != ARP_OP_REQUEST));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = needs_search ? ST_SEARCH : ST_FINISH;
				end
			end
			ST_SEARCH: begin
				if (chain[TABLE_ENTRIES].vld) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_SEARCH: in_stall = 1'b1;
			ST_FINISH: commit = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	assign launch = accept && needs_search;

	assign chain[0] = '{
		vld: launch,
		ip:  ((command == CMD_LOOKUP) ? query_ip : sender_ip),
		hit: 1'b0,
		mac: 48'd0
	};

	assign full        = (count_q >= CNTW'(TABLE_ENTRIES));
	assign do_insert   = (cmd_q == CMD_ADD) ||
		((cmd_q == CMD_PACKET) && !not_ours_q && (op_q != ARP_OP_REQUEST));
	assign write_entry = commit && do_insert && !hit_q && !full;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		arpc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (write_entry && (count_q == CNTW'(i))),
			.wr_ip   (sip_q),
			.wr_mac  (smac_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

	// Result of the item held in the command registers.
	always_comb begin
		res_status  = STAT_OK;
		res_reply   = 1'b0;
		res_request = 1'b0;
		res_dmac    = '0;
		res_dip     = '0;
		res_fmac    = '0;
		case (cmd_q)
			CMD_PACKET: begin
				if (not_ours_q) begin
					res_status = STAT_NOT_OURS;
				end else if (op_q == ARP_OP_REQUEST) begin
					res_reply = 1'b1;
					res_dmac  = smac_q;
					res_dip   = sip_q;
				end else if (!hit_q && full) begin
					res_status = STAT_FULL;
				end
			end
			CMD_LOOKUP: begin
				if (hit_q) begin
					res_fmac = fmac_q;
				end else begin
					res_status  = STAT_MISS;
					res_request = 1'b1;
					res_dip     = qip_q;
				end
			end
			CMD_ADD: begin
				if (!hit_q && full) begin
					res_status = STAT_FULL;
				end
			end
			default: res_status = STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (write_entry) begin
				count_q <= count_q + CNTW'(1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= command;
			op_q       <= arp_operation;
			sip_q      <= sender_ip;
			smac_q     <= sender_mac;
			qip_q      <= query_ip;
			not_ours_q <= not_ours;
		end
		if (state_q == ST_SEARCH && chain[TABLE_ENTRIES].vld) begin
			hit_q  <= chain[TABLE_ENTRIES].hit;
			fmac_q <= chain[TABLE_ENTRIES].mac;
		end
		if (commit) begin
			status_q  <= res_status;
			reply_q   <= res_reply;
			request_q <= res_request;
			dmac_q    <= res_dmac;
			dip_q     <= res_dip;
			found_q   <= res_fmac;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign reply_needed   = reply_q;
	assign request_needed = request_q;
	assign dest_mac       = dmac_q;
	assign dest_ip        = dip_q;
	assign found_mac      = found_q;

endmodule

### tb/sv/arp_cache_checker.sv
`timescale 1ns / 100ps

module arp_cache_checker #(
	parameter int CACHE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] arp_operation,
	input  logic [31:0] sender_ip,
	input  logic [47:0] sender_mac,
	input  logic [31:0] target_ip,
	input  logic [31:0] query_ip,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic        reply_needed,
	input  logic        request_needed,
	input  logic [47:0] dest_mac,
	input  logic [31:0] dest_ip,
	input  logic [47:0] found_mac,
	output int          mismatches,
	output int          outstanding,
	output int          answers_checked,
	output int          lookup_hits,
	output int          full_drops
);
	import arpc_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic        reply_needed;
		logic        request_needed;
		logic [47:0] dest_mac;
		logic [31:0] dest_ip;
		logic [47:0] found_mac;
	} arp_answer_t;

	logic [31:0] station_ip  = '0;
	logic [47:0] station_mac = '0;

	logic        cache_used [CACHE_DEPTH];
	logic [31:0] cache_ip   [CACHE_DEPTH];
	logic [47:0] cache_mac  [CACHE_DEPTH];
	int          cache_fill = 0;

	arp_answer_t awaited_answers [$];

	int fault_total = 0;
	int queue_depth = 0;
	int checked_total = 0;
	int hit_total = 0;
	int full_total = 0;

	assign mismatches      = fault_total;
	assign outstanding     = queue_depth;
	assign answers_checked = checked_total;
	assign lookup_hits     = hit_total;
	assign full_drops      = full_total;

	initial begin
		for (int i = 0; i < CACHE_DEPTH; i++)
			cache_used[i] = 1'b0;
	end

	// Earliest filled slot holding ip, or -1.
	function automatic int cache_find(logic [31:0] ip);
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (cache_used[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic logic [1:0] cache_store(logic [31:0] ip, logic [47:0] mac);
		if (cache_find(ip) >= 0)
			return STAT_OK;
		if (cache_fill >= CACHE_DEPTH)
			return STAT_FULL;
		cache_used[cache_fill] = 1'b1;
		cache_ip[cache_fill]   = ip;
		cache_mac[cache_fill]  = mac;
		cache_fill++;
		return STAT_OK;
	endfunction

	function automatic arp_answer_t resolve_arp_command(logic [1:0] cmd, logic [15:0] op,
			logic [31:0] sip, logic [47:0] smac, logic [31:0] tip, logic [31:0] qip);
		arp_answer_t a;
		int k;
		a = '0;
		case (cmd)
			CMD_PACKET: begin
				if (tip != station_ip) begin
					a.status = STAT_NOT_OURS;
				end else if (op == ARP_OP_REQUEST) begin
					a.reply_needed = 1'b1;
					a.dest_mac     = smac;
					a.dest_ip      = sip;
				end else begin
					// Any operation other than a request is taken as a reply and learnt.
					a.status = cache_store(sip, smac);
				end
			end
			CMD_LOOKUP: begin
				k = cache_find(qip);
				if (k >= 0) begin
					a.found_mac = cache_mac[k];
					hit_total++;
				end else begin
					a.status         = STAT_MISS;
					a.request_needed = 1'b1;
					a.dest_ip        = qip;
				end
			end
			CMD_ADD: a.status = cache_store(sip, smac);
			default: ;
		endcase
		return a;
	endfunction

	task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			fault_total++;
			if (fault_total <= 10)
				$display("%0t: %s mismatch on answer %0d: expected %0h, got %0h",
					$time, field, checked_total, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		arp_answer_t want;
		if (!arst_n) begin
			station_ip  = '0;
			station_mac = '0;
			for (int i = 0; i < CACHE_DEPTH; i++)
				cache_used[i] = 1'b0;
			cache_fill = 0;
			awaited_answers.delete();
			queue_depth <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_OWN_MAC)
					station_mac = pwdata[47:0];
				else
					station_ip = pwdata[31:0];
			end
			if (out_valid && !out_stall) begin
				if (awaited_answers.size() == 0) begin
					fault_total++;
					if (fault_total <= 10)
						$display("%0t: answer beat with nothing outstanding (status %0d)",
							$time, status);
				end else begin
					want = awaited_answers.pop_front();
					compare_field("status", 64'(want.status), 64'(status));
					compare_field("reply_needed", 64'(want.reply_needed),
						64'(reply_needed));
					compare_field("request_needed", 64'(want.request_needed),
						64'(request_needed));
					compare_field("dest_mac", 64'(want.dest_mac), 64'(dest_mac));
					compare_field("dest_ip", 64'(want.dest_ip), 64'(dest_ip));
					compare_field("found_mac", 64'(want.found_mac), 64'(found_mac));
					if (want.status == STAT_FULL)
						full_total++;
					checked_total++;
				end
			end
			if (in_valid && !in_stall)
				awaited_answers.push_back(resolve_arp_command(command, arp_operation,
					sender_ip, sender_mac, target_ip, query_ip));
			queue_depth <= awaited_answers.size();
		end
	end

endmodule

### tb/sv/arp_cache_and_responder_top_tb.sv
`timescale 1ns / 100ps

module arp_cache_and_responder_top_tb;
	import arpc_pkg::*;

	localparam int          CACHE_DEPTH  = 16;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;
	localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
	localparam int          POOL_SIZE    = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [15:0] arp_operation = '0;
	logic [31:0] sender_ip = '0;
	logic [47:0] sender_mac = '0;
	logic [31:0] target_ip = '0;
	logic [31:0] query_ip = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        reply_needed;
	logic        request_needed;
	logic [47:0] dest_mac;
	logic [31:0] dest_ip;
	logic [47:0] found_mac;

	int mismatches;
	int outstanding;
	int answers_checked;
	int lookup_hits;
	int full_drops;

	logic        idling = 1'b0;
	int          stall_left = 0;
	int          commands_sent = 0;
	logic [31:0] station_ip = '0;
	logic [31:0] ip_pool [POOL_SIZE];

	arp_cache_and_responder_top #(.TABLE_ENTRIES(CACHE_DEPTH)) dut (.*);

	arp_cache_checker #(.CACHE_DEPTH(CACHE_DEPTH)) checker_i (.*);

	always #6 clk = ~clk;

	initial begin
		#3_000_000;
		$display("** arp_cache_and_responder_top: FAILED **");
		$finish;
	end

	// Random receiver back-pressure in bursts, only while idling is set.
	always @(posedge clk) begin
		if (!idling) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_command(logic [1:0] cmd, logic [15:0] op, logic [31:0] sip,
			logic [47:0] smac, logic [31:0] tip, logic [31:0] qip);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		arp_operation <= op;
		sender_ip     <= sip;
		sender_mac    <= smac;
		target_ip     <= tip;
		query_ip      <= qip;
		do @(posedge clk); while (in_stall);
		commands_sent++;
	endtask

	// Holds the sender back until every answer has been taken.
	task automatic drain_answers();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_register(logic idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_station(logic [31:0] ip, logic [47:0] mac);
		write_register(REG_OWN_IP, {32'h0, ip});
		write_register(REG_OWN_MAC, {16'h0, mac});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		station_ip = ip;
	endtask

	task automatic random_command();
		int pick;
		logic [1:0]  cmd;
		logic [15:0] op;
		logic [31:0] sip;
		logic [47:0] smac;
		logic [31:0] tip;
		logic [31:0] qip;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			cmd = CMD_PACKET;
		else if (pick < 80)
			cmd = CMD_LOOKUP;
		else if (pick < 95)
			cmd = CMD_ADD;
		else
			cmd = CMD_UNUSED;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			op = ARP_OP_REQUEST;
		else if (pick < 8)
			op = ARP_OP_REPLY;
		else
			op = 16'($urandom);
		// A small address pool keeps duplicates and lookup hits frequent.
		sip = ($urandom_range(0, 4) == 0) ? $urandom : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		qip = ($urandom_range(0, 4) == 0) ? $urandom : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		smac = 48'({$urandom, $urandom});
		pick = $urandom_range(0, 9);
		if (pick < 7)
			tip = station_ip;
		else if (pick < 9)
			tip = station_ip ^ (32'd1 << $urandom_range(0, 31));
		else
			tip = $urandom;
		push_command(cmd, op, sip, smac, tip, qip);
	endtask

	initial begin
		logic [31:0] phase_ip  [4];
		logic [47:0] phase_mac [4];
		int          phase_len [4];
		phase_ip[0] = 32'hC0A8_0001;  phase_mac[0] = 48'({$urandom, $urandom});
		phase_len[0] = 170;
		phase_ip[1] = 32'hFFFF_FFFF;  phase_mac[1] = 48'hFFFF_FFFF_FFFF;    phase_len[1] = 160;
		phase_ip[2] = 32'h0;          phase_mac[2] = 48'h0;                 phase_len[2] = 160;
		phase_ip[3] = $urandom;       phase_mac[3] = 48'({$urandom, $urandom});
		phase_len[3] = 160;
		ip_pool[0] = 32'h0;
		ip_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_station(phase_ip[0], phase_mac[0]);
		idling = 1'b1;

		// Directed part: empty table, foreign packets, requests, learning and duplicates.
		push_command(CMD_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0);
		push_command(CMD_PACKET, ARP_OP_REQUEST, ip_pool[2], 48'h1, station_ip ^ 32'h1, 32'h0);
		push_command(CMD_PACKET, ARP_OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			station_ip, 32'h0);
		push_command(CMD_PACKET, ARP_OP_REPLY, 32'h0, 48'h0, station_ip, 32'h0);
		push_command(CMD_PACKET, 16'h0000, ip_pool[2], 48'({$urandom, $urandom}),
			station_ip, 32'h0);
		push_command(CMD_PACKET, 16'hFFFF, ip_pool[3], 48'({$urandom, $urandom}),
			station_ip, 32'h0);
		push_command(CMD_PACKET, ARP_OP_REPLY, 32'h0, 48'hFFFF_FFFF_FFFF, station_ip, 32'h0);
		push_command(CMD_ADD, 16'h0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0);
		push_command(CMD_ADD, 16'h0, 32'hFFFF_FFFF, 48'h0, 32'h0, 32'h0);
		push_command(CMD_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, 32'h0);
		push_command(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_command(CMD_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, ip_pool[3]);
		push_command(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_command(CMD_LOOKUP, 16'h0, 32'h0, 48'h0, 32'h0, ip_pool[4]);
		push_command(CMD_PACKET, ARP_OP_REQUEST, ip_pool[4], 48'h2, 32'hFFFF_FFFF, 32'h0);
		push_command(CMD_ADD, 16'hFFFF, ip_pool[4], 48'({$urandom, $urandom}),
			32'hFFFF_FFFF, 32'hFFFF_FFFF);

		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				drain_answers();
				set_station(phase_ip[p], phase_mac[p]);
			end
			for (int n = 0; n < phase_len[p]; n++) begin
				// No idling in the final phase, and quiet windows in the others.
				idling = (p < 3) && ((n % 60) < 45);
				if (p == 0 && n == 100)
					drain_answers();
				random_command();
			end
		end

		drain_answers();
		repeat (CACHE_DEPTH + 4) @(posedge clk);

		$display("Sent %0d commands over four station addresses, %0d answers checked.",
			commands_sent, answers_checked);
		$display("Lookup hits %0d, inserts dropped on a full cache %0d, mismatches %0d.",
			lookup_hits, full_drops, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("** arp_cache_and_responder_top: PASSED **");
		else
			$display("** arp_cache_and_responder_top: FAILED **");
		$finish;
	end

endmodule
